// ----- hdl/prs_pkg.sv -----
// Package for the precharge relay supervisor: transfer payload structs, config struct,
// mode and register codes, relay drive bit positions and reset defaults.
// No dependencies.
package prs_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_IDLE = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;
  localparam logic [1:0] MODE_ERR  = 2'd3;

  localparam logic [2:0] REG_PRECHARGE_STEP = 3'd0;
  localparam logic [2:0] REG_COIL_PULSE     = 3'd1;
  localparam logic [2:0] REG_COIL_GAP       = 3'd2;
  localparam logic [2:0] REG_MAIN_SETTLE    = 3'd3;
  localparam logic [2:0] REG_OFF_GAP        = 3'd4;
  localparam logic [2:0] REG_ERROR_LIMIT    = 3'd5;
  localparam logic [2:0] REG_IDLE_BLINK     = 3'd6;
  localparam logic [2:0] REG_RUN_BLINK      = 3'd7;

  localparam logic [4:0] PH_NONE      = 5'd0;
  localparam logic [4:0] PH_PRE_FIRST = 5'd1;
  localparam logic [4:0] PH_PRE_LAST  = 5'd5;
  localparam logic [4:0] PH_ON_GAP    = 5'd6;
  localparam logic [4:0] PH_ON_PULSE  = 5'd7;
  localparam logic [4:0] PH_SETTLE    = 5'd8;
  localparam logic [4:0] PH_OFF_FIRST = 5'd9;

  localparam logic [1:0] SUB_GAP   = 2'd0;
  localparam logic [1:0] SUB_PULSE = 2'd1;

  localparam int DRV_EN  = 5;
  localparam int DRV_ON  = 6;
  localparam int DRV_OFF = 7;
  localparam int DRV_LED = 8;

  localparam int DEF_TIMER_WIDTH     = 10;
  localparam int DEF_ERROR_BLINK_DIV = 5;
  localparam int DEF_OFF_PULSES      = 3;

  localparam logic [9:0] RST_PRECHARGE_STEP = 10'd250;
  localparam logic [9:0] RST_COIL_PULSE     = 10'd250;
  localparam logic [9:0] RST_COIL_GAP       = 10'd10;
  localparam logic [9:0] RST_MAIN_SETTLE    = 10'd200;
  localparam logic [9:0] RST_OFF_GAP        = 10'd50;
  localparam logic [4:0] RST_ERROR_LIMIT    = 5'd20;
  localparam logic [7:0] RST_IDLE_BLINK     = 8'd50;
  localparam logic [7:0] RST_RUN_BLINK      = 8'd10;

  typedef struct packed {
    logic ms_tick;
    logic machine_tick;
    logic on_request;
    logic error_present;
    logic buffers_ready;
  } prs_in_t;

  typedef struct packed {
    logic [4:0] precharge_relays;
    logic       enable_relay;
    logic       main_on_coil;
    logic       main_off_coil;
    logic       status_led;
    logic [1:0] mode;
    logic       sequence_busy;
    logic [4:0] error_total;
    logic       halted;
  } prs_out_t;

  typedef struct packed {
    logic [9:0] precharge_step_ms;
    logic [9:0] coil_pulse_ms;
    logic [9:0] coil_gap_ms;
    logic [9:0] main_settle_ms;
    logic [9:0] off_gap_ms;
    logic [4:0] error_limit;
    logic [7:0] idle_blink_div;
    logic [7:0] run_blink_div;
  } prs_cfg_t;

endpackage

// ----- hdl/prs_cfg.sv -----
// APB-style configuration register file of the precharge relay supervisor.
// Depends on prs_pkg.
module prs_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [prs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [prs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [prs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output prs_pkg::prs_cfg_t                cfg_o
);
  import prs_pkg::*;

  prs_cfg_t   cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.precharge_step_ms <= RST_PRECHARGE_STEP;
      cfg_q.coil_pulse_ms     <= RST_COIL_PULSE;
      cfg_q.coil_gap_ms       <= RST_COIL_GAP;
      cfg_q.main_settle_ms    <= RST_MAIN_SETTLE;
      cfg_q.off_gap_ms        <= RST_OFF_GAP;
      cfg_q.error_limit       <= RST_ERROR_LIMIT;
      cfg_q.idle_blink_div    <= RST_IDLE_BLINK;
      cfg_q.run_blink_div     <= RST_RUN_BLINK;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRECHARGE_STEP: cfg_q.precharge_step_ms <= pwdata[9:0];
        REG_COIL_PULSE:     cfg_q.coil_pulse_ms     <= pwdata[9:0];
        REG_COIL_GAP:       cfg_q.coil_gap_ms       <= pwdata[9:0];
        REG_MAIN_SETTLE:    cfg_q.main_settle_ms    <= pwdata[9:0];
        REG_OFF_GAP:        cfg_q.off_gap_ms        <= pwdata[9:0];
        REG_ERROR_LIMIT:    cfg_q.error_limit       <= pwdata[4:0];
        REG_IDLE_BLINK:     cfg_q.idle_blink_div    <= pwdata[7:0];
        REG_RUN_BLINK:      cfg_q.run_blink_div     <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PRECHARGE_STEP: prdata = CFG_DATA_W'(cfg_q.precharge_step_ms);
      REG_COIL_PULSE:     prdata = CFG_DATA_W'(cfg_q.coil_pulse_ms);
      REG_COIL_GAP:       prdata = CFG_DATA_W'(cfg_q.coil_gap_ms);
      REG_MAIN_SETTLE:    prdata = CFG_DATA_W'(cfg_q.main_settle_ms);
      REG_OFF_GAP:        prdata = CFG_DATA_W'(cfg_q.off_gap_ms);
      REG_ERROR_LIMIT:    prdata = CFG_DATA_W'(cfg_q.error_limit);
      REG_IDLE_BLINK:     prdata = CFG_DATA_W'(cfg_q.idle_blink_div);
      REG_RUN_BLINK:      prdata = CFG_DATA_W'(cfg_q.run_blink_div);
    endcase
  end

endmodule

// ----- hdl/prs_engine.sv -----
// Supervisor state and single-pass next-state logic: mode machine, relay sequencer,
// phase timer, LED blink and error counter. Depends on prs_pkg.
module prs_engine #(
  parameter int TIMER_WIDTH     = prs_pkg::DEF_TIMER_WIDTH,
  parameter int ERROR_BLINK_DIV = prs_pkg::DEF_ERROR_BLINK_DIV,
  parameter int OFF_PULSES      = prs_pkg::DEF_OFF_PULSES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  prs_pkg::prs_in_t   in_i,
  input  prs_pkg::prs_cfg_t  cfg_i,
  output prs_pkg::prs_out_t  res_o
);
  import prs_pkg::*;

  localparam logic [4:0] PhOffLast = 5'(PH_OFF_FIRST + 3 * OFF_PULSES - 1);
  localparam logic [7:0] ErrDiv    = 8'(ERROR_BLINK_DIV);

  function automatic logic [1:0] off_sub(logic [4:0] p);
    logic [4:0] v;
    logic [9:0] prod;
    logic [6:0] rem;
    v    = p - PH_OFF_FIRST;
    prod = 10'(v) * 10'd11;
    rem  = 7'(v) - 7'(prod[9:5]) * 7'd3;
    return rem[1:0];
  endfunction

  logic [1:0]             mode_q, mode_d, target_q, target_d;
  logic [4:0]             phase_q, phase_d, enter_p;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic                   pending_q, pending_d, halt_q, halt_d;
  logic [7:0]             blink_q, blink_d, blink_div;
  logic [4:0]             err_q, err_d;
  logic [8:0]             drive_q, drive_d;
  logic                   enter, blink_en;

  always_comb begin
    mode_d    = mode_q;
    target_d  = target_q;
    phase_d   = phase_q;
    timer_d   = timer_q;
    pending_d = pending_q;
    halt_d    = halt_q;
    blink_d   = blink_q;
    err_d     = err_q;
    drive_d   = drive_q;
    enter     = 1'b0;
    enter_p   = PH_NONE;
    blink_en  = 1'b0;
    blink_div = ErrDiv;

    if (step_i && !halt_q) begin
      if (phase_q != PH_NONE) begin
        if (in_i.machine_tick) pending_d = 1'b1;
        if (in_i.ms_tick && timer_q != '0) timer_d = timer_q - 1'b1;
        if (timer_d == '0) begin
          if ((phase_q >= PH_PRE_FIRST && phase_q < PH_SETTLE) ||
              (phase_q >= PH_OFF_FIRST && phase_q < PhOffLast)) begin
            enter   = 1'b1;
            enter_p = phase_q + 5'd1;
          end else begin
            if (phase_q == PH_SETTLE) begin
              drive_d[4:0]   = '0;
              drive_d[DRV_EN] = 1'b1;
            end
            phase_d = PH_NONE;
            timer_d = '0;
            mode_d  = target_q;
          end
        end
      end else if (in_i.machine_tick || pending_q) begin
        pending_d = 1'b0;
        unique case (mode_q)
          MODE_INIT: begin
            drive_d[DRV_LED] = 1'b1;
            if (in_i.buffers_ready) begin
              if (!in_i.error_present) begin
                target_d        = MODE_IDLE;
                drive_d[4:0]    = '0;
                drive_d[DRV_EN] = 1'b0;
                enter           = 1'b1;
                enter_p         = PH_OFF_FIRST;
              end else begin
                mode_d = MODE_ERR;
              end
            end
          end
          MODE_IDLE: begin
            blink_en  = 1'b1;
            blink_div = cfg_i.idle_blink_div;
            if (in_i.on_request) begin
              target_d = MODE_RUN;
              enter    = 1'b1;
              enter_p  = PH_PRE_FIRST;
            end
          end
          MODE_RUN: begin
            blink_en  = 1'b1;
            blink_div = cfg_i.run_blink_div;
            if (!in_i.on_request) begin
              target_d        = MODE_IDLE;
              drive_d[4:0]    = '0;
              drive_d[DRV_EN] = 1'b0;
              enter           = 1'b1;
              enter_p         = PH_OFF_FIRST;
            end
          end
          MODE_ERR: begin
            blink_en = 1'b1;
            if (err_q != 5'd31) err_d = err_q + 5'd1;
            if (err_d >= cfg_i.error_limit) begin
              halt_d = 1'b1;
            end else begin
              drive_d[DRV_LED] = ~drive_d[DRV_LED];
              mode_d           = MODE_INIT;
            end
          end
        endcase
      end
    end

    if (blink_en) begin
      if (blink_q >= blink_div) begin
        drive_d[DRV_LED] = ~drive_d[DRV_LED];
        blink_d          = '0;
      end else begin
        blink_d = blink_q + 8'd1;
      end
    end

    if (enter) begin
      if (enter_p >= PH_PRE_FIRST && enter_p <= PH_PRE_LAST) begin
        drive_d = drive_d | (9'd1 << (enter_p - 5'd1));
        timer_d = TIMER_WIDTH'(cfg_i.precharge_step_ms);
      end else if (enter_p == PH_ON_GAP) begin
        drive_d[DRV_OFF] = 1'b0;
        timer_d          = TIMER_WIDTH'(cfg_i.coil_gap_ms);
      end else if (enter_p == PH_ON_PULSE) begin
        drive_d[DRV_ON] = 1'b1;
        timer_d         = TIMER_WIDTH'(cfg_i.coil_pulse_ms);
      end else if (enter_p == PH_SETTLE) begin
        drive_d[DRV_ON] = 1'b0;
        timer_d         = TIMER_WIDTH'(cfg_i.main_settle_ms);
      end else if (off_sub(enter_p) == SUB_GAP) begin
        drive_d[DRV_ON] = 1'b0;
        timer_d         = TIMER_WIDTH'(cfg_i.coil_gap_ms);
      end else if (off_sub(enter_p) == SUB_PULSE) begin
        drive_d[DRV_OFF] = 1'b1;
        timer_d          = TIMER_WIDTH'(cfg_i.coil_pulse_ms);
      end else begin
        drive_d[DRV_OFF] = 1'b0;
        timer_d          = TIMER_WIDTH'(cfg_i.off_gap_ms);
      end
      phase_d = enter_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_INIT;
      target_q  <= MODE_INIT;
      phase_q   <= PH_NONE;
      timer_q   <= '0;
      pending_q <= 1'b0;
      halt_q    <= 1'b0;
      blink_q   <= '0;
      err_q     <= '0;
      drive_q   <= '0;
    end else begin
      mode_q    <= mode_d;
      target_q  <= target_d;
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      pending_q <= pending_d;
      halt_q    <= halt_d;
      blink_q   <= blink_d;
      err_q     <= err_d;
      drive_q   <= drive_d;
    end
  end

  always_comb begin
    res_o.precharge_relays = drive_d[4:0];
    res_o.enable_relay     = drive_d[DRV_EN];
    res_o.main_on_coil     = drive_d[DRV_ON];
    res_o.main_off_coil    = drive_d[DRV_OFF];
    res_o.status_led       = drive_d[DRV_LED];
    res_o.mode             = mode_d;
    res_o.sequence_busy    = (phase_d != PH_NONE);
    res_o.error_total      = err_d;
    res_o.halted           = halt_d;
  end

endmodule

// ----- hdl/precharge_relay_supervisor_core.sv -----
// Top level of the precharge relay supervisor: input register, result register,
// handshake control and assertions. Depends on prs_pkg, prs_cfg and prs_engine.

// One input transfer can be taken every clock cycle, and each gives exactly one result
// transfer. An accepted item sits in the input register. In the cycle in which it
// advances, the supervisor logic updates its state and loads the result register,
// from which the result is offered. The rate is set by the state update. It runs in
// any cycle in which the result register is empty or its result is taken. A stalled
// result holds the input register, and that stalls the input.
// Configuration registers sit at byte addresses 4*i of the APB-style port and should
// be written only while no item is in flight.
module precharge_relay_supervisor_core #(
  parameter int TIMER_WIDTH     = prs_pkg::DEF_TIMER_WIDTH,
  parameter int ERROR_BLINK_DIV = prs_pkg::DEF_ERROR_BLINK_DIV,
  parameter int OFF_PULSES      = prs_pkg::DEF_OFF_PULSES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  prs_pkg::prs_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output prs_pkg::prs_out_t               out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [prs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [prs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import prs_pkg::*;

  prs_cfg_t cfg;
  prs_in_t  in_q;
  prs_out_t out_q, res;
  logic     in_valid_q, out_valid_q, advance, accept;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  prs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prs_engine #(
    .TIMER_WIDTH     (TIMER_WIDTH),
    .ERROR_BLINK_DIV (ERROR_BLINK_DIV),
    .OFF_PULSES      (OFF_PULSES)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .in_i   (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (advance) out_q <= res;
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.halted |=> out_q.halted)
    else $error("halted result followed by a result that is not halted");

  a_coils_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> !(out_q.main_on_coil && out_q.main_off_coil))
    else $error("main relay on and off coils driven together");

  a_enable_vs_precharge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> !(out_q.enable_relay && (out_q.precharge_relays != '0)))
    else $error("enable relay closed while a precharge relay is closed");

  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room to advance");

endmodule

// ----- test/relay_supervisor_checker.sv -----
`timescale 1ns / 100ps
// Checker for the precharge relay supervisor: watches the input, result and register
// ports, keeps its own model of the supervisor and compares every result transfer.
// Depends on prs_pkg.
module relay_supervisor_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  prs_pkg::prs_in_t                in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  prs_pkg::prs_out_t               out_data_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [prs_pkg::CFG_ADDR_W-1:0]  paddr_i,
  input  logic [prs_pkg::CFG_DATA_W-1:0]  pwdata_i,
  output int                              fails_o,
  output int                              awaited_o,
  output int                              checked_o
);
  import prs_pkg::*;

  localparam int TW = DEF_TIMER_WIDTH;
  localparam logic [4:0] PH_OFF_LAST = PH_OFF_FIRST + 5'(3 * DEF_OFF_PULSES - 1);
  localparam logic [7:0] ERR_DIV = 8'(DEF_ERROR_BLINK_DIV);

  prs_cfg_t        cfg;
  logic [1:0]      mode;
  logic [1:0]      target;
  logic [4:0]      phase;
  logic [TW-1:0]   timer;
  logic            tick_held;
  logic [7:0]      blink_cnt;
  logic [4:0]      err_cnt;
  logic            halt;
  logic [4:0]      pre;
  logic            en;
  logic            on_coil;
  logic            off_coil;
  logic            led;
  prs_out_t        relay_status_q[$];
  prs_out_t        want_status;

  function automatic void open_phase(input logic [4:0] p);
    int sub;
    sub = (int'(p) - int'(PH_OFF_FIRST)) % 3;
    if (p >= PH_PRE_FIRST && p <= PH_PRE_LAST) begin
      pre[int'(p) - 1] = 1'b1;
      timer = TW'(cfg.precharge_step_ms);
    end else if (p == PH_ON_GAP) begin
      off_coil = 1'b0;
      timer = TW'(cfg.coil_gap_ms);
    end else if (p == PH_ON_PULSE) begin
      on_coil = 1'b1;
      timer = TW'(cfg.coil_pulse_ms);
    end else if (p == PH_SETTLE) begin
      on_coil = 1'b0;
      timer = TW'(cfg.main_settle_ms);
    end else if (sub == int'(SUB_GAP)) begin
      on_coil = 1'b0;
      timer = TW'(cfg.coil_gap_ms);
    end else if (sub == int'(SUB_PULSE)) begin
      off_coil = 1'b1;
      timer = TW'(cfg.coil_pulse_ms);
    end else begin
      off_coil = 1'b0;
      timer = TW'(cfg.off_gap_ms);
    end
    phase = p;
  endfunction

  function automatic void close_phase();
    if ((phase >= PH_PRE_FIRST && phase < PH_SETTLE) ||
        (phase >= PH_OFF_FIRST && phase < PH_OFF_LAST)) begin
      open_phase(phase + 5'd1);
    end else begin
      if (phase == PH_SETTLE) begin
        pre = '0;
        en  = 1'b1;
      end
      phase = PH_NONE;
      timer = '0;
      mode  = target;
    end
  endfunction

  function automatic void blink_led(input logic [7:0] div);
    if (blink_cnt >= div) begin
      led = ~led;
      blink_cnt = '0;
    end else begin
      blink_cnt = blink_cnt + 8'd1;
    end
  endfunction

  function automatic void begin_power_down();
    target = MODE_IDLE;
    pre = '0;
    en = 1'b0;
    open_phase(PH_OFF_FIRST);
  endfunction

  function automatic void supervise_mode(input prs_in_t d);
    case (mode)
      MODE_INIT: begin
        led = 1'b1;
        if (d.buffers_ready) begin
          if (!d.error_present) begin
            begin_power_down();
          end else begin
            mode = MODE_ERR;
          end
        end
      end
      MODE_IDLE: begin
        blink_led(cfg.idle_blink_div);
        if (d.on_request) begin
          target = MODE_RUN;
          open_phase(PH_PRE_FIRST);
        end
      end
      MODE_RUN: begin
        blink_led(cfg.run_blink_div);
        if (!d.on_request) begin
          begin_power_down();
        end
      end
      default: begin
        blink_led(ERR_DIV);
        if (err_cnt != 5'd31) begin
          err_cnt = err_cnt + 5'd1;
        end
        if (err_cnt >= cfg.error_limit) begin
          halt = 1'b1;
        end else begin
          led = ~led;
          mode = MODE_INIT;
        end
      end
    endcase
  endfunction

  function automatic prs_out_t step_supervisor(input prs_in_t d);
    prs_out_t s;
    if (!halt) begin
      if (phase != PH_NONE) begin
        if (d.machine_tick) begin
          tick_held = 1'b1;
        end
        if (d.ms_tick && timer != '0) begin
          timer = timer - 1'b1;
        end
        if (timer == '0) begin
          close_phase();
        end
      end else if (d.machine_tick || tick_held) begin
        tick_held = 1'b0;
        supervise_mode(d);
      end
    end
    s.precharge_relays = pre;
    s.enable_relay     = en;
    s.main_on_coil     = on_coil;
    s.main_off_coil    = off_coil;
    s.status_led       = led;
    s.mode             = mode;
    s.sequence_busy    = (phase != PH_NONE);
    s.error_total      = err_cnt;
    s.halted           = halt;
    return s;
  endfunction

  task automatic check_field(input string name, input logic [4:0] want,
                             input logic [4:0] got);
    if (want !== got) begin
      fails_o++;
      if (fails_o <= 10) begin
        $display("%0t: result %0d %s expected %0d got %0d",
                 $realtime, checked_o, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.precharge_step_ms = RST_PRECHARGE_STEP;
      cfg.coil_pulse_ms     = RST_COIL_PULSE;
      cfg.coil_gap_ms       = RST_COIL_GAP;
      cfg.main_settle_ms    = RST_MAIN_SETTLE;
      cfg.off_gap_ms        = RST_OFF_GAP;
      cfg.error_limit       = RST_ERROR_LIMIT;
      cfg.idle_blink_div    = RST_IDLE_BLINK;
      cfg.run_blink_div     = RST_RUN_BLINK;
      mode      = MODE_INIT;
      target    = MODE_INIT;
      phase     = PH_NONE;
      timer     = '0;
      tick_held = 1'b0;
      blink_cnt = '0;
      err_cnt   = '0;
      halt      = 1'b0;
      pre       = '0;
      en        = 1'b0;
      on_coil   = 1'b0;
      off_coil  = 1'b0;
      led       = 1'b0;
      relay_status_q.delete();
      fails_o   = 0;
      awaited_o = 0;
      checked_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_PRECHARGE_STEP: cfg.precharge_step_ms = pwdata_i[9:0];
          REG_COIL_PULSE:     cfg.coil_pulse_ms     = pwdata_i[9:0];
          REG_COIL_GAP:       cfg.coil_gap_ms       = pwdata_i[9:0];
          REG_MAIN_SETTLE:    cfg.main_settle_ms    = pwdata_i[9:0];
          REG_OFF_GAP:        cfg.off_gap_ms        = pwdata_i[9:0];
          REG_ERROR_LIMIT:    cfg.error_limit       = pwdata_i[4:0];
          REG_IDLE_BLINK:     cfg.idle_blink_div    = pwdata_i[7:0];
          default:            cfg.run_blink_div     = pwdata_i[7:0];
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        relay_status_q.push_back(step_supervisor(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (relay_status_q.size() == 0) begin
          fails_o++;
          if (fails_o <= 10) begin
            $display("%0t: result transfer with no input behind it", $realtime);
          end
        end else begin
          want_status = relay_status_q.pop_front();
          check_field("precharge_relays", want_status.precharge_relays,
                      out_data_i.precharge_relays);
          check_field("enable_relay", 5'(want_status.enable_relay),
                      5'(out_data_i.enable_relay));
          check_field("main_on_coil", 5'(want_status.main_on_coil),
                      5'(out_data_i.main_on_coil));
          check_field("main_off_coil", 5'(want_status.main_off_coil),
                      5'(out_data_i.main_off_coil));
          check_field("status_led", 5'(want_status.status_led),
                      5'(out_data_i.status_led));
          check_field("mode", 5'(want_status.mode), 5'(out_data_i.mode));
          check_field("sequence_busy", 5'(want_status.sequence_busy),
                      5'(out_data_i.sequence_busy));
          check_field("error_total", want_status.error_total, out_data_i.error_total);
          check_field("halted", 5'(want_status.halted), 5'(out_data_i.halted));
        end
        checked_o++;
      end
      awaited_o = relay_status_q.size();
    end
  end

endmodule

// ----- test/tb_precharge_relay_supervisor_core.sv -----
`timescale 1ns / 100ps
// Testbench top for precharge_relay_supervisor_core: clock, reset, register writes,
// input stimulus, result stall and verdict. Depends on prs_pkg and relay_supervisor_checker.
module tb_precharge_relay_supervisor_core;
  import prs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  prs_in_t                 in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  prs_out_t                out_data;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr = '0;
  logic [CFG_DATA_W-1:0]   pwdata = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  int   fails;
  int   awaited;
  int   checked;
  int   sent = 0;
  int   settings = 0;
  int   stuck = 0;
  int   stall_left = 0;
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  logic on_level = 1'b0;

  always #6 clk_i = ~clk_i;

  precharge_relay_supervisor_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  relay_supervisor_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fails_o     (fails),
    .awaited_o   (awaited),
    .checked_o   (checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic chance(input int pct);
    return ($urandom_range(0, 99) < pct);
  endfunction

  function automatic prs_in_t stim(input logic ms, input logic mt, input logic on,
                                   input logic err, input logic rdy);
    prs_in_t d;
    d.ms_tick       = ms;
    d.machine_tick  = mt;
    d.on_request    = on;
    d.error_present = err;
    d.buffers_ready = rdy;
    return d;
  endfunction

  function automatic prs_cfg_t make_cfg(input int step, input int pulse, input int gap,
                                        input int settle, input int off_gap,
                                        input int limit, input int idle_div,
                                        input int run_div);
    prs_cfg_t c;
    c.precharge_step_ms = 10'(step);
    c.coil_pulse_ms     = 10'(pulse);
    c.coil_gap_ms       = 10'(gap);
    c.main_settle_ms    = 10'(settle);
    c.off_gap_ms        = 10'(off_gap);
    c.error_limit       = 5'(limit);
    c.idle_blink_div    = 8'(idle_div);
    c.run_blink_div     = 8'(run_div);
    return c;
  endfunction

  function automatic prs_cfg_t random_cfg(input int tmax, input int dmax);
    return make_cfg($urandom_range(1, tmax), $urandom_range(1, tmax),
                    $urandom_range(0, tmax), $urandom_range(0, tmax),
                    $urandom_range(0, tmax), $urandom_range(1, 31),
                    $urandom_range(0, dmax), $urandom_range(0, dmax));
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input prs_cfg_t c);
    reg_write(REG_PRECHARGE_STEP, 32'(c.precharge_step_ms));
    reg_write(REG_COIL_PULSE,     32'(c.coil_pulse_ms));
    reg_write(REG_COIL_GAP,       32'(c.coil_gap_ms));
    reg_write(REG_MAIN_SETTLE,    32'(c.main_settle_ms));
    reg_write(REG_OFF_GAP,        32'(c.off_gap_ms));
    reg_write(REG_ERROR_LIMIT,    32'(c.error_limit));
    reg_write(REG_IDLE_BLINK,     32'(c.idle_blink_div));
    reg_write(REG_RUN_BLINK,      32'(c.run_blink_div));
    settings++;
  endtask

  task automatic push_item(input prs_in_t d);
    int n;
    n = tx_steady ? 0 : pick_gap();
    repeat (n) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input prs_cfg_t c, input int count, input int ms_pct,
                           input int mt_pct);
    drain();
    configure(c);
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) on_level = ~on_level;
      push_item(stim(chance(ms_pct), chance(mt_pct), on_level,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = rx_steady ? 0 : pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("No transfer for %0d cycles, %0d results still awaited", stuck, awaited);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int ticks_left;
    logic mt;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    configure(make_cfg(2, 1, 0, 0, 1, 31, 0, 1));
    // initializing: stray ms tick, not ready, then two error passes
    push_item(stim(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    push_item(stim(1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
    push_item(stim(1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
    push_item(stim(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    push_item(stim(1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
    push_item(stim(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));

    // hold the error flag so the block cycles between initializing and error
    ticks_left = 40;
    repeat (120) begin
      mt = (ticks_left > 0) && chance(40);
      if (mt) ticks_left--;
      push_item(stim(chance(50), mt, 1'($urandom_range(0, 1)), 1'b1,
                     1'($urandom_range(0, 1))));
    end

    // leave initializing, stack machine ticks during power-down, then power up
    push_item(stim(1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
    push_item(stim(1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
    push_item(stim(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    push_item(stim(1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    push_item(stim(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    repeat (6) push_item(stim(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    repeat (3) push_item(stim(1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
    on_level = 1'b1;

    run_phase(make_cfg($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 3),
                       $urandom_range(0, 3), $urandom_range(0, 3), 31,
                       $urandom_range(0, 3), $urandom_range(0, 3)), 250, 70, 30);
    run_phase(make_cfg(1, 1, 0, 0, 0, 1, 0, 0), 200, 50, 50);
    run_phase(random_cfg(6, 15), 200, 85, 15);
    run_phase(random_cfg(2, 255), 150, 60, 60);
    run_phase(make_cfg(1023, 1023, 1023, 1023, 1023, 31, 255, 255), 760, 97, 20);

    drain();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d input transfers over %0d register settings, %0d results compared",
             sent, settings, checked);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fails);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/prs_pkg.sv
hdl/prs_cfg.sv
hdl/prs_engine.sv
hdl/precharge_relay_supervisor_core.sv
test/relay_supervisor_checker.sv
test/tb_precharge_relay_supervisor_core.sv
